FILE: rtl/core/wcs_pkg.sv
`default_nettype none

package wcs_pkg;

    localparam int MAX_LINE_SAMPLES = 5;
    localparam int K_W = $clog2(MAX_LINE_SAMPLES + 1);

    localparam int ONE_Q14   = 16384;
    localparam int POS0_BASE = 9830;
    localparam int POS1_BASE = 55706;
    localparam int POS_GAIN  = 3277;
    localparam int PARA_BASE = 3277;
    localparam int PARA_GAIN = 1311;
    localparam int HOOK_BASE = 512;
    localparam int LINE_A    = 21627;
    localparam int LINE_B    = 43254;

    // config register indexes
    localparam logic [1:0] REG_SHORT_SEG  = 2'd0;
    localparam logic [1:0] REG_END_CLAMP  = 2'd1;
    localparam logic [1:0] REG_LINE_SHORT = 2'd2;
    localparam logic [1:0] REG_LINE_STEP  = 2'd3;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
    } pt_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } uv_t;

    typedef struct packed {
        logic signed [27:0] x;
        logic signed [27:0] y;
    } wpt_t;

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic               point_last;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] out_x;
        logic signed [23:0] out_y;
        logic               out_last;
        logic               out_error;
    } out_item_t;

    // round to nearest, halves away from zero
    function automatic logic signed [55:0] rsh_rnd(input logic signed [55:0] v,
                                                   input int unsigned s);
        logic [55:0] mag;
        logic [55:0] r;
        mag = v[55] ? 56'(-v) : 56'(v);
        r = (mag + (56'd1 << (s - 1))) >> s;
        rsh_rnd = v[55] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        if (v > 28'sd8388607)
            sat24 = 24'sh7FFFFF;
        else if (v < -28'sd8388608)
            sat24 = 24'sh800000;
        else
            sat24 = v[23:0];
    endfunction

    function automatic logic signed [15:0] clamp_cos(input logic signed [55:0] dot);
        logic signed [55:0] r;
        r = rsh_rnd(dot, 14);
        if (r > 56'sd16384)
            clamp_cos = 16'sd16384;
        else if (r < -56'sd16384)
            clamp_cos = -16'sd16384;
        else
            clamp_cos = r[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/wcs_dir.sv
`default_nettype none

// Direction unit: unit vector (Q1.14) and Q.8 length of b - a.
// Bit-serial square root, then restoring division per component.
module wcs_dir import wcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire pt_t         a,
    input  wire pt_t         b,
    output logic             done,
    output uv_t              u,
    output logic [25:0]      len8
);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_SQX  = 3'd1;
    localparam logic [2:0] D_SQY  = 3'd2;
    localparam logic [2:0] D_SQRT = 3'd3;
    localparam logic [2:0] D_DIVI = 3'd4;
    localparam logic [2:0] D_DIV  = 3'd5;
    localparam logic [2:0] D_DONE = 3'd6;

    logic [2:0]         st_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic [63:0]        v_reg, res_reg, bit_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        len_reg;
    logic [31:0]        rem_reg;
    logic [16:0]        nsh_reg;
    logic [16:0]        q_reg;
    logic               ysel_reg;
    uv_t                u_reg;

    logic signed [24:0] dsel;
    logic signed [49:0] sq;
    logic [63:0]        trial;
    logic               sq_ge;
    logic [63:0]        res_nx;
    logic [24:0]        mag;
    logic [45:0]        num;
    logic [32:0]        r33;
    logic               dv_ge;
    logic [16:0]        qn;
    logic [15:0]        qc;
    logic               neg;

    always_comb
    begin
        dsel  = (st_reg == D_SQX) ? dx_reg : dy_reg;
        sq    = dsel * dsel;
        trial = res_reg + bit_reg;
        sq_ge = v_reg >= trial;
        res_nx = sq_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
        neg   = ysel_reg ? dy_reg[24] : dx_reg[24];
        mag   = ysel_reg ? (dy_reg[24] ? 25'(-dy_reg) : 25'(dy_reg))
                         : (dx_reg[24] ? 25'(-dx_reg) : 25'(dx_reg));
        num   = {mag, 21'd0} + 46'(len_reg[31:1]);
        r33   = {rem_reg, nsh_reg[16]};
        dv_ge = r33 >= {1'b0, len_reg};
        qn    = {q_reg[15:0], dv_ge};
        qc    = (qn > 17'd16384) ? 16'd16384 : qn[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= D_IDLE;
        end
        else
        begin
            unique case (st_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        dx_reg <= 25'(b.x) - 25'(a.x);
                        dy_reg <= 25'(b.y) - 25'(a.y);
                        st_reg <= D_SQX;
                    end
                end
                D_SQX:
                begin
                    v_reg  <= {14'd0, sq};
                    st_reg <= D_SQY;
                end
                D_SQY:
                begin
                    v_reg   <= (v_reg + {14'd0, sq}) << 14;
                    res_reg <= '0;
                    bit_reg <= 64'd1 << 62;
                    cnt_reg <= '0;
                    st_reg  <= D_SQRT;
                end
                D_SQRT:
                begin
                    if (sq_ge)
                        v_reg <= v_reg - trial;
                    res_reg <= res_nx;
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        len_reg  <= res_nx[31:0];
                        ysel_reg <= 1'b0;
                        st_reg   <= D_DIVI;
                    end
                end
                D_DIVI:
                begin
                    if (len_reg == 32'd0)
                    begin
                        u_reg  <= '0;
                        st_reg <= D_DONE;
                    end
                    else
                    begin
                        rem_reg <= {3'd0, num[45:17]};
                        nsh_reg <= num[16:0];
                        q_reg   <= '0;
                        cnt_reg <= '0;
                        st_reg  <= D_DIV;
                    end
                end
                D_DIV:
                begin
                    rem_reg <= dv_ge ? 32'(r33 - {1'b0, len_reg}) : r33[31:0];
                    q_reg   <= qn;
                    nsh_reg <= nsh_reg << 1;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd16)
                    begin
                        if (!ysel_reg)
                        begin
                            u_reg.x  <= neg ? -$signed(qc) : $signed(qc);
                            ysel_reg <= 1'b1;
                            st_reg   <= D_DIVI;
                        end
                        else
                        begin
                            u_reg.y <= neg ? -$signed(qc) : $signed(qc);
                            st_reg  <= D_DONE;
                        end
                    end
                end
                D_DONE:
                begin
                    st_reg <= D_IDLE;
                end
                default:
                begin
                    st_reg <= D_IDLE;
                end
            endcase
        end
    end

    logic [32:0] len_rnd;
    assign len_rnd = {1'b0, len_reg} + 33'd64;
    assign len8 = len_rnd[32:7];
    assign done = (st_reg == D_DONE);
    assign u    = u_reg;

endmodule

`default_nettype wire

FILE: rtl/core/waypoint_corner_smoother_top.sv
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------
// in       | in_valid / in_ready  | in_item  (point_x, point_y, point_last)
// out      | out_valid / out_ready| out_item (out_x, out_y, out_last, out_error)
// cfg      | cfg_wr_en            | cfg_index, cfg_data (16 bit)
//
// A waypoint that is only buffered is taken in the idle state, and a
// too-short polyline ends in an error item. The time that a shaping or a
// final waypoint takes, output stalls apart, is set by the direction unit:
// a 32-step square root and two 17-step divisions per direction, up to three
// directions per item; a zero-length segment skips the divisions.
// The rest runs on one shared 28x28 multiplier under a step counter.
// Reset is asynchronous, active low; it resets control state and config only.
// in_ready is high only while idle; a stalled output holds the sequencer.
module waypoint_corner_smoother_top import wcs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_DIR1 = 4'd2;
    localparam logic [3:0] S_DIR2 = 4'd3;
    localparam logic [3:0] S_CALC = 4'd4;
    localparam logic [3:0] S_DIR3 = 4'd5;
    localparam logic [3:0] S_EMIT = 4'd6;
    localparam logic [3:0] S_LINE = 4'd7;

    // config registers
    logic [15:0] ssl_reg, ecl_reg, lsl_reg, lstp_reg;

    // sequencer and point state
    logic [3:0]  state_reg;
    logic [1:0]  seen_reg;
    pt_t         older_reg, newer_reg, p_reg, s_reg;
    uv_t         prior_reg, u_reg, nxt_reg, lu_reg;
    logic        last_reg, first_reg, shrt_reg;
    logic [25:0] dis_reg, ld_reg, la_reg, lb_reg;
    logic [4:0]  step_reg;
    logic signed [55:0] acc_reg, prod_reg;
    logic signed [15:0] c0_reg, c1_reg;
    logic [15:0] para0_reg, para1_reg, pos0_reg, pos1_reg;
    logic signed [27:0] d1_reg, d2_reg, t_reg, lx_reg, ly_reg;
    wpt_t        p1_reg, mid_reg, p3_reg;
    logic [1:0]  em_reg, lstep_reg;
    logic [K_W-1:0] k_reg;
    logic [26:0] at_reg;
    logic        long_reg, empty_reg;
    logic        dstart_reg;
    logic [1:0]  dsel_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    // direction unit
    pt_t         dir_a, dir_b;
    logic        dir_done;
    uv_t         dir_u;
    logic [25:0] dir_len;

    always_comb
    begin
        unique case (dsel_reg)
            2'd0:    begin dir_a = older_reg; dir_b = newer_reg; end
            2'd1:    begin dir_a = newer_reg; dir_b = p_reg; end
            default: begin dir_a = s_reg;     dir_b = p_reg; end
        endcase
    end

    wcs_dir u_dir (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart_reg),
        .a     (dir_a),
        .b     (dir_b),
        .done  (dir_done),
        .u     (dir_u),
        .len8  (dir_len)
    );

    // shared multiplier, operands picked by the state and its step counter
    logic signed [27:0] mul_a, mul_b;
    uv_t                prev;
    logic [14:0]        m0, m1;

    always_comb
    begin
        prev = first_reg ? '0 : prior_reg;
        m0 = 15'(ONE_Q14 - (c0_reg[15] ? -c0_reg : c0_reg));
        m1 = 15'(ONE_Q14 - (c1_reg[15] ? -c1_reg : c1_reg));
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_CALC)
        begin
            unique case (step_reg)
                5'd0:  begin mul_a = 28'(prev.x);  mul_b = 28'(u_reg.x); end
                5'd1:  begin mul_a = 28'(prev.y);  mul_b = 28'(u_reg.y); end
                5'd2:  begin mul_a = 28'(u_reg.x); mul_b = 28'(nxt_reg.x); end
                5'd3:  begin mul_a = 28'(u_reg.y); mul_b = 28'(nxt_reg.y); end
                5'd5:  begin mul_a = $signed({13'd0, m0}); mul_b = 28'(PARA_GAIN); end
                5'd6:  begin mul_a = $signed({13'd0, m0}); mul_b = 28'(POS_GAIN); end
                5'd7:  begin mul_a = $signed({13'd0, m1}); mul_b = 28'(PARA_GAIN); end
                5'd8:  begin mul_a = $signed({13'd0, m1}); mul_b = 28'(POS_GAIN); end
                5'd10: begin mul_a = $signed({12'd0, pos0_reg}); mul_b = $signed({2'd0, dis_reg}); end
                5'd11: begin mul_a = $signed({12'd0, pos1_reg}); mul_b = $signed({2'd0, dis_reg}); end
                5'd14: begin mul_a = 28'(u_reg.x); mul_b = d1_reg; end
                5'd15: begin mul_a = 28'(prev.x);  mul_b = $signed({12'd0, para0_reg}); end
                5'd16: begin mul_a = 28'(u_reg.y); mul_b = d1_reg; end
                5'd17: begin mul_a = 28'(prev.y);  mul_b = $signed({12'd0, para0_reg}); end
                5'd19: begin mul_a = 28'(u_reg.x); mul_b = $signed({2'd0, dis_reg}); end
                5'd20: begin mul_a = 28'(u_reg.y); mul_b = $signed({2'd0, dis_reg}); end
                5'd21: begin mul_a = 28'(u_reg.x); mul_b = d2_reg; end
                5'd22: begin mul_a = 28'(nxt_reg.x); mul_b = $signed({12'd0, para1_reg}); end
                5'd23: begin mul_a = 28'(u_reg.y); mul_b = d2_reg; end
                5'd24: begin mul_a = 28'(nxt_reg.y); mul_b = $signed({12'd0, para1_reg}); end
                5'd27: begin mul_a = $signed({2'd0, ld_reg}); mul_b = 28'(LINE_A); end
                5'd28: begin mul_a = $signed({2'd0, ld_reg}); mul_b = 28'(LINE_B); end
                default: ;
            endcase
        end
        else if (state_reg == S_LINE)
        begin
            if (lstep_reg == 2'd0)
            begin
                mul_a = 28'(lu_reg.x); mul_b = $signed({1'b0, at_reg});
            end
            else if (lstep_reg == 2'd1)
            begin
                mul_a = 28'(lu_reg.y); mul_b = $signed({1'b0, at_reg});
            end
        end
    end

    // rounded views of the last product
    logic signed [27:0] r14, r15, r16, r23;
    logic signed [55:0] r14w, r15w, r16w, r23w;
    always_comb
    begin
        r14w = rsh_rnd(prod_reg, 14);
        r15w = rsh_rnd(prod_reg, 15);
        r16w = rsh_rnd(prod_reg, 16);
        r23w = rsh_rnd(prod_reg, 23);
        r14 = r14w[27:0];
        r15 = r15w[27:0];
        r16 = r16w[27:0];
        r23 = r23w[27:0];
    end

    // hook and short-segment test
    logic               hk0, hk1;
    logic signed [27:0] d1h, d2h, dis_s, ecl_s, d2lo;
    logic signed [31:0] d1x5, d2x5, dis2, dis3;
    logic               shrt_c;
    always_comb
    begin
        dis_s = $signed({2'd0, dis_reg});
        ecl_s = $signed({12'd0, ecl_reg});
        d2lo  = dis_s - ecl_s;
        hk0 = !first_reg && c0_reg[15];
        hk1 = c1_reg[15];
        d1h = hk0 ? d1_reg + 28'(HOOK_BASE) + 28'(($signed(-c0_reg) + 16'sd4) >>> 3)
                  : d1_reg;
        d2h = hk1 ? d2_reg - 28'(HOOK_BASE) - 28'(($signed(-c1_reg) + 16'sd4) >>> 3)
                  : d2_reg;
        d1x5 = (32'(d1h) <<< 2) + 32'(d1h);
        d2x5 = (32'(d2h) <<< 2) + 32'(d2h);
        dis2 = 32'(dis_s) <<< 1;
        dis3 = (32'(dis_s) <<< 1) + 32'(dis_s);
        shrt_c = (dis_reg < 26'(ssl_reg)) || (hk0 && (d1x5 > dis2))
                 || (hk1 && (d2x5 < dis3));
    end

    // emission bookkeeping
    logic        slot_free;
    logic        em_on, em_final;
    wpt_t        em_pt;
    logic [15:0] step_eff;
    logic [26:0] at_nx;
    logic        line_final;
    logic        load;
    out_item_t   load_item;

    always_comb
    begin
        slot_free = !out_valid_reg || out_ready;
        em_on = (em_reg == 2'd0 && first_reg) || (em_reg == 2'd1 && !shrt_reg)
                || (em_reg == 2'd2) || (em_reg == 2'd3 && !shrt_reg);
        em_final = (em_reg == 2'd3) || (em_reg == 2'd2 && shrt_reg);
        unique case (em_reg)
            2'd0:    em_pt = '{x: 28'(older_reg.x), y: 28'(older_reg.y)};
            2'd1:    em_pt = p1_reg;
            2'd2:    em_pt = mid_reg;
            default: em_pt = p3_reg;
        endcase
        step_eff = (lstp_reg == 16'd0) ? 16'd1 : lstp_reg;
        at_nx = at_reg + 27'(step_eff);
        line_final = long_reg ? (k_reg == K_W'(1))
                              : ((k_reg == K_W'(MAX_LINE_SAMPLES - 1))
                                 || (at_nx >= 27'(ld_reg)));
        load = 1'b0;
        load_item = '0;
        if (state_reg == S_ERR && slot_free)
        begin
            load = 1'b1;
            load_item.out_last  = 1'b1;
            load_item.out_error = 1'b1;
        end
        else if (state_reg == S_EMIT && em_on && slot_free)
        begin
            load = 1'b1;
            load_item.out_x = sat24(em_pt.x);
            load_item.out_y = sat24(em_pt.y);
            load_item.out_last = last_reg && empty_reg && em_final;
        end
        else if (state_reg == S_LINE && lstep_reg == 2'd3 && slot_free)
        begin
            load = 1'b1;
            load_item.out_x = sat24(lx_reg);
            load_item.out_y = sat24(ly_reg);
            load_item.out_last = line_final;
        end
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssl_reg  <= 16'd1280;
            ecl_reg  <= 16'd768;
            lsl_reg  <= 16'd512;
            lstp_reg <= 16'd102;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SHORT_SEG:  ssl_reg  <= cfg_data;
                REG_END_CLAMP:  ecl_reg  <= cfg_data;
                REG_LINE_SHORT: lsl_reg  <= cfg_data;
                REG_LINE_STEP:  lstp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (load)
            out_reg <= load_item;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            seen_reg   <= 2'd0;
            dstart_reg <= 1'b0;
            dsel_reg   <= 2'd0;
        end
        else
        begin
            dstart_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        p_reg    <= '{x: in_item.point_x, y: in_item.point_y};
                        last_reg <= in_item.point_last;
                        if (seen_reg < 2'd2)
                        begin
                            if (in_item.point_last)
                                state_reg <= S_ERR;
                            else
                            begin
                                older_reg <= newer_reg;
                                newer_reg <= '{x: in_item.point_x, y: in_item.point_y};
                                seen_reg  <= seen_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            first_reg  <= (seen_reg == 2'd2);
                            dsel_reg   <= 2'd0;
                            dstart_reg <= 1'b1;
                            state_reg  <= S_DIR1;
                        end
                    end
                end
                S_ERR:
                begin
                    if (slot_free)
                    begin
                        seen_reg  <= 2'd0;
                        state_reg <= S_IDLE;
                    end
                end
                S_DIR1:
                begin
                    if (dir_done)
                    begin
                        u_reg      <= dir_u;
                        dis_reg    <= dir_len;
                        dsel_reg   <= 2'd1;
                        dstart_reg <= 1'b1;
                        state_reg  <= S_DIR2;
                    end
                end
                S_DIR2:
                begin
                    if (dir_done)
                    begin
                        nxt_reg   <= dir_u;
                        step_reg  <= 5'd0;
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    step_reg <= step_reg + 5'd1;
                    unique case (step_reg)
                        5'd1:  acc_reg <= prod_reg;
                        5'd2:  c0_reg <= first_reg ? 16'(ONE_Q14)
                                                   : clamp_cos(acc_reg + prod_reg);
                        5'd3:  acc_reg <= prod_reg;
                        5'd4:  c1_reg <= clamp_cos(acc_reg + prod_reg);
                        5'd6:  para0_reg <= 16'(PARA_BASE) + r14[15:0];
                        5'd7:  pos0_reg  <= 16'(POS0_BASE) + r14[15:0];
                        5'd8:  para1_reg <= 16'(PARA_BASE) + r14[15:0];
                        5'd9:  pos1_reg  <= 16'(POS1_BASE) - r14[15:0];
                        5'd11: d1_reg <= (r16 > ecl_s) ? ecl_s : r16;
                        5'd12: d2_reg <= (r16 < d2lo) ? d2lo : r16;
                        5'd13:
                        begin
                            d1_reg   <= d1h;
                            d2_reg   <= d2h;
                            shrt_reg <= shrt_c;
                        end
                        5'd15: t_reg <= 28'(older_reg.x) + r14;
                        5'd16: p1_reg.x <= t_reg - r23;
                        5'd17: t_reg <= 28'(older_reg.y) + r14;
                        5'd18: p1_reg.y <= t_reg - r23;
                        5'd20: mid_reg.x <= 28'(older_reg.x) + r15;
                        5'd21: mid_reg.y <= 28'(older_reg.y) + r15;
                        5'd22: t_reg <= 28'(older_reg.x) + r14;
                        5'd23: p3_reg.x <= t_reg + r23;
                        5'd24: t_reg <= 28'(older_reg.y) + r14;
                        5'd25: p3_reg.y <= t_reg + r23;
                        5'd26:
                        begin
                            // final shaped point is where the line sample starts
                            s_reg.x   <= sat24(shrt_reg ? mid_reg.x : p3_reg.x);
                            s_reg.y   <= sat24(shrt_reg ? mid_reg.y : p3_reg.y);
                            em_reg    <= 2'd0;
                            empty_reg <= 1'b0;
                            if (last_reg)
                            begin
                                dsel_reg   <= 2'd2;
                                dstart_reg <= 1'b1;
                                state_reg  <= S_DIR3;
                            end
                            else
                                state_reg <= S_EMIT;
                        end
                        5'd28: la_reg <= r16[25:0];
                        5'd29:
                        begin
                            lb_reg    <= r16[25:0];
                            state_reg <= S_EMIT;
                        end
                        default: ;
                    endcase
                end
                S_DIR3:
                begin
                    if (dir_done)
                    begin
                        lu_reg    <= dir_u;
                        ld_reg    <= dir_len;
                        long_reg  <= !(dir_len < 26'(lsl_reg));
                        empty_reg <= (dir_len < 26'(lsl_reg)) && (dir_len == 26'd0);
                        if (!(dir_len < 26'(lsl_reg)))
                        begin
                            step_reg  <= 5'd27;
                            state_reg <= S_CALC;
                        end
                        else
                            state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!em_on || slot_free)
                    begin
                        em_reg <= em_reg + 2'd1;
                        if (em_reg == 2'd3)
                        begin
                            if (last_reg && !empty_reg)
                            begin
                                k_reg     <= '0;
                                at_reg    <= long_reg ? 27'(la_reg) : 27'd0;
                                lstep_reg <= 2'd0;
                                state_reg <= S_LINE;
                            end
                            else if (last_reg)
                            begin
                                seen_reg  <= 2'd0;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                prior_reg <= u_reg;
                                older_reg <= newer_reg;
                                newer_reg <= p_reg;
                                seen_reg  <= 2'd3;
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end
                S_LINE:
                begin
                    unique case (lstep_reg)
                        2'd0: lstep_reg <= 2'd1;
                        2'd1:
                        begin
                            lx_reg    <= 28'(s_reg.x) + r14;
                            lstep_reg <= 2'd2;
                        end
                        2'd2:
                        begin
                            ly_reg    <= 28'(s_reg.y) + r14;
                            lstep_reg <= 2'd3;
                        end
                        default:
                        begin
                            if (slot_free)
                            begin
                                if (line_final)
                                begin
                                    seen_reg  <= 2'd0;
                                    state_reg <= S_IDLE;
                                end
                                else
                                begin
                                    k_reg     <= k_reg + K_W'(1);
                                    at_reg    <= long_reg ? 27'(lb_reg) : at_nx;
                                    lstep_reg <= 2'd0;
                                end
                            end
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire
